// ===== design/alist_pkg.sv =====
// Shared constants, types and codes for the array list engine.
// Depends on nothing; every design file refers to it by scoped names.
package alist_pkg;

  // Store depth and the widths that follow from it.
  localparam int unsigned CAPACITY = 128;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths on the streams.
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned FIDX_W   = 7;
  localparam int unsigned TOT_W    = 8;

  // Width used when the request position is compared with the entry count.
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned IN_RAW_W  = FUNC_W + POS_W + 2 * DATA_W;
  localparam int unsigned IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W = STAT_W + DATA_W + FIDX_W + TOT_W;
  localparam int unsigned OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STAT_W-1:0] status_t;

  // Request kinds.
  localparam func_t FN_APPEND = 3'd0;
  localparam func_t FN_INSERT = 3'd1;
  localparam func_t FN_POP    = 3'd2;
  localparam func_t FN_REMOVE = 3'd3;
  localparam func_t FN_FIND   = 3'd4;
  localparam func_t FN_CLEAR  = 3'd5;

  // Result status codes.
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_BADPOS   = 3'd2;
  localparam status_t ST_EMPTY    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

endpackage

// ===== design/array_list_engine.sv =====
// Array list engine top level: list store, entry count, request sequencer.
// Depends on alist_pkg for widths, request kinds and status codes.
//
//  Channel | Ports                              | Payload (lowest bit first)
//  --------+------------------------------------+------------------------------------------
//  request | in_tvalid, in_tready, in_tdata     | func, position, item_value, search_key
//  result  | out_tvalid, out_tready, out_tdata  | status, removed_value, found_index,
//          |                                    | entry_total
//
// One request is worked on at a time. Append, clear, unknown kinds and rejected requests
// go from the accept straight to the result load. Insert, remove and find walk the store
// first: insert moves the entries at and above the position up, then writes the new
// entry; remove reads out the removed entry and moves the entries above it down; find
// reads from the bottom until the first match. The walks visit the store one entry per
// cycle, each read overlapping the write-back of the entry read in the cycle before.
// Reset clears the entry count and the control state; the store itself is not cleared,
// since no entry at or above the count is ever read. A stalled result holds the last
// step; the next request is taken as soon as the engine is back in its idle state,
// even while the previous result still waits in the output register.
module array_list_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  // Request stream.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // in_tdata: [2:0] func, [10:3] position, [42:11] item_value, [74:43] search_key,
  // upper bits zero.
  input  logic [alist_pkg::IN_W-1:0]  in_tdata,
  // Result stream.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // out_tdata: [2:0] status, [34:3] removed_value, [41:35] found_index,
  // [49:42] entry_total, upper bits zero.
  output logic [alist_pkg::OUT_W-1:0] out_tdata
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_FIND = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Field offsets within the request word.
  localparam int unsigned IN_POS_LO = alist_pkg::FUNC_W;
  localparam int unsigned IN_VAL_LO = IN_POS_LO + alist_pkg::POS_W;
  localparam int unsigned IN_KEY_LO = IN_VAL_LO + alist_pkg::DATA_W;

  // List store: one write and one registered read per cycle.
  alist_pkg::data_t mem [alist_pkg::CAPACITY];
  alist_pkg::data_t rd_data_r;
  logic             mem_we;
  alist_pkg::idx_t  mem_waddr;
  alist_pkg::data_t mem_wdata;
  logic             mem_re;
  alist_pkg::idx_t  mem_raddr;

  // Control state.
  logic [2:0]        state_r, state_nxt;
  alist_pkg::cnt_t   count_r, count_nxt;
  alist_pkg::cnt_t   ptr_r,   ptr_nxt;
  logic              pend_r,  pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Request and working payload.
  alist_pkg::cnt_t    pos_r,     pos_nxt;
  alist_pkg::data_t   val_r,     val_nxt;
  alist_pkg::data_t   key_r,     key_nxt;
  logic               skip_r,    skip_nxt;
  alist_pkg::idx_t    wb_addr_r, wb_addr_nxt;
  alist_pkg::status_t st_r,      st_nxt;
  alist_pkg::data_t   rem_r,     rem_nxt;
  alist_pkg::idx_t    idx_r,     idx_nxt;

  // Output register payload.
  alist_pkg::status_t out_st_r,    out_st_nxt;
  alist_pkg::data_t   out_rem_r,   out_rem_nxt;
  alist_pkg::idx_t    out_idx_r,   out_idx_nxt;
  alist_pkg::cnt_t    out_total_r, out_total_nxt;

  // Unpacked request fields.
  alist_pkg::func_t  in_func;
  logic [alist_pkg::POS_W-1:0] in_pos;
  alist_pkg::data_t  in_val;
  alist_pkg::data_t  in_key;
  alist_pkg::cmp_t   in_pos_ext;
  alist_pkg::cmp_t   count_ext;
  logic              in_accept;
  logic              list_full;

  assign in_func    = in_tdata[alist_pkg::FUNC_W-1:0];
  assign in_pos     = in_tdata[IN_VAL_LO-1:IN_POS_LO];
  assign in_val     = in_tdata[IN_KEY_LO-1:IN_VAL_LO];
  assign in_key     = in_tdata[IN_KEY_LO+alist_pkg::DATA_W-1:IN_KEY_LO];
  assign in_pos_ext = alist_pkg::cmp_t'(in_pos);
  assign count_ext  = alist_pkg::cmp_t'(count_r);
  assign list_full  = (count_r >= alist_pkg::cnt_t'(alist_pkg::CAPACITY));

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = alist_pkg::OUT_W'({alist_pkg::TOT_W'(out_total_r),
                                         alist_pkg::FIDX_W'(out_idx_r),
                                         out_rem_r, out_st_r});

  // Store ports. In the shift walks the read address and the pending write address
  // are always two entries apart, so no read ever meets a write to the same entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    key_nxt       = key_r;
    skip_nxt      = skip_r;
    wb_addr_nxt   = wb_addr_r;
    st_nxt        = st_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_rem_nxt   = out_rem_r;
    out_idx_nxt   = out_idx_r;
    out_total_nxt = out_total_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    // A taken result empties the output register unless a new one is loaded below.
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          val_nxt   = in_val;
          key_nxt   = in_key;
          st_nxt    = alist_pkg::ST_OK;
          rem_nxt   = '0;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          skip_nxt  = 1'b0;
          state_nxt = S_DONE;
          unique case (in_func)
            alist_pkg::FN_APPEND: begin
              if (list_full) begin
                st_nxt = alist_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[alist_pkg::IDX_W-1:0];
                mem_wdata = in_val;
                count_nxt = count_r + 1'b1;
              end
            end
            alist_pkg::FN_INSERT: begin
              if (list_full) begin
                st_nxt = alist_pkg::ST_FULL;
              end else if (in_pos_ext > count_ext) begin
                st_nxt = alist_pkg::ST_BADPOS;
              end else begin
                pos_nxt   = alist_pkg::cnt_t'(in_pos_ext);
                ptr_nxt   = count_r;
                state_nxt = S_INS;
              end
            end
            alist_pkg::FN_POP: begin
              // Removing the last entry is a positional remove with nothing to shift.
              if (count_r == '0) begin
                st_nxt = alist_pkg::ST_EMPTY;
              end else begin
                pos_nxt   = count_r - 1'b1;
                ptr_nxt   = count_r - 1'b1;
                state_nxt = S_DEL;
              end
            end
            alist_pkg::FN_REMOVE: begin
              if (count_r == '0) begin
                st_nxt = alist_pkg::ST_EMPTY;
              end else if (in_pos_ext >= count_ext) begin
                st_nxt = alist_pkg::ST_BADPOS;
              end else begin
                pos_nxt   = alist_pkg::cnt_t'(in_pos_ext);
                ptr_nxt   = alist_pkg::cnt_t'(in_pos_ext);
                state_nxt = S_DEL;
              end
            end
            alist_pkg::FN_FIND: begin
              ptr_nxt   = '0;
              state_nxt = S_FIND;
            end
            alist_pkg::FN_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              // Unused request kinds leave the list alone and report success.
            end
          endcase
        end
      end

      S_INS: begin
        // Walk down from the top, moving each entry one place up.
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wb_addr_r;
          mem_wdata = rd_data_r;
        end
        if (ptr_r > pos_r) begin
          mem_re      = 1'b1;
          mem_raddr   = alist_pkg::idx_t'(ptr_r - 1'b1);
          pend_nxt    = 1'b1;
          wb_addr_nxt = ptr_r[alist_pkg::IDX_W-1:0];
          ptr_nxt     = ptr_r - 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            mem_we    = 1'b1;
            mem_waddr = pos_r[alist_pkg::IDX_W-1:0];
            mem_wdata = val_r;
            count_nxt = count_r + 1'b1;
            state_nxt = S_DONE;
          end
        end
      end

      S_DEL: begin
        // The first read returns the removed entry; later reads move one place down.
        if (pend_r) begin
          if (skip_r) begin
            rem_nxt = rd_data_r;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wb_addr_r;
            mem_wdata = rd_data_r;
          end
        end
        if (ptr_r < count_r) begin
          mem_re      = 1'b1;
          mem_raddr   = ptr_r[alist_pkg::IDX_W-1:0];
          pend_nxt    = 1'b1;
          skip_nxt    = (ptr_r == pos_r);
          wb_addr_nxt = alist_pkg::idx_t'(ptr_r - 1'b1);
          ptr_nxt     = ptr_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_DONE;
          end
        end
      end

      S_FIND: begin
        // Reads run one entry ahead of the compare; the first match ends the walk.
        if (pend_r && (rd_data_r == key_r)) begin
          idx_nxt   = wb_addr_r;
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (ptr_r < count_r) begin
          mem_re      = 1'b1;
          mem_raddr   = ptr_r[alist_pkg::IDX_W-1:0];
          pend_nxt    = 1'b1;
          wb_addr_nxt = ptr_r[alist_pkg::IDX_W-1:0];
          ptr_nxt     = ptr_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            st_nxt    = alist_pkg::ST_NOTFOUND;
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = st_r;
          out_rem_nxt   = rem_r;
          out_idx_nxt   = idx_r;
          out_total_nxt = count_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    key_r       <= key_nxt;
    skip_r      <= skip_nxt;
    wb_addr_r   <= wb_addr_nxt;
    st_r        <= st_nxt;
    rem_r       <= rem_nxt;
    idx_r       <= idx_nxt;
    out_st_r    <= out_st_nxt;
    out_rem_r   <= out_rem_nxt;
    out_idx_r   <= out_idx_nxt;
    out_total_r <= out_total_nxt;
  end

endmodule
